### hw/rtl/bfrs_pkg.sv
// ----------------------------------------------------------------------------
// bfrs_pkg
// Shared sizes, register codes, queue and result types and the reciprocal
// table of the box filter running sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bfrs_pkg;

  // Largest supported geometry
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 15;
  localparam int MAX_HEIGHT = 4096;

  // Field and counter widths
  localparam int PIX_W    = 8;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WID_W    = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W    = $clog2(MAX_HEIGHT + 1);
  localparam int K_W      = $clog2(MAX_KERNEL + 1);
  localparam int SLOT_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int COLSUM_W = 12;
  localparam int WSUM_W   = 16;

  // Configuration port
  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_K_W    = 4;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 480;
  localparam int RST_KERNEL = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KERNEL_SIZE  = 2'd2
  } cfg_idx_t;

  // Line store holds one row per window line
  localparam int LS_DEPTH = MAX_KERNEL * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  // Division by k*k as multiply by a scaled reciprocal
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = WSUM_W + RECIP_W;
  localparam int QUOT_W   = PROD_W - RECIP_SH;
  localparam int MEAN_MAX = 255;

  // Queue between front and back, and the result buffer
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int OF_DEPTH  = 8;
  localparam int OF_AW     = $clog2(OF_DEPTH);
  localparam int OF_CNT_W  = $clog2(OF_DEPTH + 1);

  // One classified pixel on its way to the back end
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [LS_AW-1:0]  ls_addr;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] hslot;
    logic              r_zero;
    logic              r_ge_k;
    logic              c_zero;
    logic              c_ge_k;
    logic              emit;
    logic              row_end;
    logic              frame_end;
  } bfrs_entry_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic             row_end;
    logic             frame_end;
  } bfrs_result_t;

  // ceil(2^24 / k^2); exact floor division for any 16-bit window sum
  function automatic logic [RECIP_W-1:0] bfrs_recip(input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] m;
    case (k)
      4'd2:    m = RECIP_W'(4194304);
      4'd3:    m = RECIP_W'(1864136);
      4'd4:    m = RECIP_W'(1048576);
      4'd5:    m = RECIP_W'(671089);
      4'd6:    m = RECIP_W'(466034);
      4'd7:    m = RECIP_W'(342393);
      4'd8:    m = RECIP_W'(262144);
      4'd9:    m = RECIP_W'(207127);
      4'd10:   m = RECIP_W'(167773);
      4'd11:   m = RECIP_W'(138655);
      4'd12:   m = RECIP_W'(116509);
      4'd13:   m = RECIP_W'(99274);
      4'd14:   m = RECIP_W'(85599);
      4'd15:   m = RECIP_W'(74566);
      default: m = RECIP_W'(16777216);
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bfrs_in_if.sv
// ----------------------------------------------------------------------------
// bfrs_in_if
// Pixel channel: valid/ready handshake carrying one grey pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfrs_in_if;
  import bfrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

### hw/rtl/bfrs_out_if.sv
// ----------------------------------------------------------------------------
// bfrs_out_if
// Result channel: valid/ready handshake carrying one mean pixel per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfrs_out_if;
  import bfrs_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] mean_value;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output mean_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input mean_value, input row_end, input frame_end,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/bfrs_ram.sv
// ----------------------------------------------------------------------------
// bfrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, and read old contents on an address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/bfrs_front.sv
// ----------------------------------------------------------------------------
// bfrs_front
// Input side: tracks column, row and window slots of each pixel and hands a
// classified word to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  logic [bfrs_pkg::WID_W-1:0] w_eff,
  input  logic [bfrs_pkg::HGT_W-1:0] h_eff,
  input  logic [bfrs_pkg::K_W-1:0]   k_eff,
  bfrs_in_if.sink                    in_pix,
  input  logic                       q_full,
  output logic                       q_push,
  output bfrs_pkg::bfrs_entry_t      q_entry
);
  import bfrs_pkg::*;

  logic [COL_W-1:0]  col_r,   col_nxt;
  logic [ROW_W-1:0]  row_r,   row_nxt;
  logic [SLOT_W-1:0] slot_r,  slot_nxt;
  logic [SLOT_W-1:0] hslot_r, hslot_nxt;

  logic [WID_W-1:0] col_inc;
  logic [HGT_W-1:0] row_inc;
  logic [K_W-1:0]   slot_inc;
  logic [K_W-1:0]   hslot_inc;
  logic             col_last;
  logic             row_last;

  // Accept whenever the queue has room
  assign in_pix.ready = !q_full;
  assign q_push       = in_pix.valid && !q_full;

  assign col_inc   = WID_W'(col_r) + WID_W'(1);
  assign row_inc   = HGT_W'(row_r) + HGT_W'(1);
  assign slot_inc  = K_W'(slot_r) + K_W'(1);
  assign hslot_inc = K_W'(hslot_r) + K_W'(1);
  assign col_last  = (col_inc == w_eff);
  assign row_last  = (row_inc == h_eff);

  // Classify the pixel
  always_comb begin
    q_entry.pixel     = in_pix.pixel;
    q_entry.ls_addr   = LS_AW'(slot_r) * LS_AW'(MAX_WIDTH) + LS_AW'(col_r);
    q_entry.col       = col_r;
    q_entry.hslot     = hslot_r;
    q_entry.r_zero    = (row_r == '0);
    q_entry.r_ge_k    = (HGT_W'(row_r) >= HGT_W'(k_eff));
    q_entry.c_zero    = (col_r == '0);
    q_entry.c_ge_k    = (WID_W'(col_r) >= WID_W'(k_eff));
    q_entry.emit      = (row_inc >= HGT_W'(k_eff)) && (col_inc >= WID_W'(k_eff));
    q_entry.row_end   = col_last;
    q_entry.frame_end = col_last && row_last;
  end

  // Advance position; wrap columns, rows and window slots
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    slot_nxt  = slot_r;
    hslot_nxt = hslot_r;
    if (restart) begin
      col_nxt   = '0;
      row_nxt   = '0;
      slot_nxt  = '0;
      hslot_nxt = '0;
    end else if (q_push) begin
      if (col_last) begin
        col_nxt   = '0;
        hslot_nxt = '0;
        if (row_last) begin
          row_nxt  = '0;
          slot_nxt = '0;
        end else begin
          row_nxt  = ROW_W'(row_inc);
          slot_nxt = (slot_inc == k_eff) ? '0 : SLOT_W'(slot_inc);
        end
      end else begin
        col_nxt   = COL_W'(col_inc);
        hslot_nxt = (hslot_inc == k_eff) ? '0 : SLOT_W'(hslot_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      slot_r  <= '0;
      hslot_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      slot_r  <= slot_nxt;
      hslot_r <= hslot_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bfrs_queue.sv
// ----------------------------------------------------------------------------
// bfrs_queue
// Short queue of classified pixel words between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrs_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bfrs_pkg::bfrs_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output bfrs_pkg::bfrs_entry_t pop_data,
  output logic                  empty
);
  import bfrs_pkg::*;

  bfrs_entry_t     mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   cnt_r,    cnt_nxt;

  assign full     = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ((wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1))
                      : wr_ptr_r;
    rd_ptr_nxt = pop  ? ((rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1))
                      : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_AW + 1)'(push) - (Q_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bfrs_back.sv
// ----------------------------------------------------------------------------
// bfrs_back
// Execution side: vertical and horizontal running sums, division by k*k and
// the result buffer that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bfrs_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bfrs_pkg::K_W-1:0] k_eff,
  input  logic                     q_empty,
  input  bfrs_pkg::bfrs_entry_t    q_head,
  output logic                     q_pop,
  bfrs_out_if.source               out_res
);
  import bfrs_pkg::*;

  // Read stage: word whose RAM data is now on the read ports
  logic                v2_r;
  bfrs_entry_t         s2_r;
  logic                fwd_ls_r, fwd_cs_r;
  logic [PIX_W-1:0]    last_px_r;
  logic [COLSUM_W-1:0] last_col_r;

  logic [PIX_W-1:0]    ls_rdata;
  logic [COLSUM_W-1:0] cs_rdata;
  logic [PIX_W-1:0]    old_px;
  logic [COLSUM_W-1:0] cs_in;
  logic [COLSUM_W-1:0] col_new;
  logic [WSUM_W-1:0]   ws_base;
  logic [COLSUM_W-1:0] ws_sub;

  // Running state
  logic [COLSUM_W-1:0] recent_r [MAX_KERNEL];
  logic [WSUM_W-1:0]   ws_r, ws_nxt;
  logic [RECIP_W-1:0]  recip_r;

  // Multiply and result stages
  logic                v3_r, v4_r;
  logic                row_end3_r, frame_end3_r;
  logic                row_end4_r, frame_end4_r;
  logic [PROD_W-1:0]   prod_r;
  logic [QUOT_W-1:0]   quot;
  bfrs_result_t        res;

  // Result buffer
  bfrs_result_t        of_mem_r [OF_DEPTH];
  logic [OF_AW-1:0]    of_wr_r, of_rd_r;
  logic [OF_CNT_W-1:0] of_cnt_r;
  logic                of_pop;
  logic [OF_CNT_W:0]   committed;

  // Pop only when every word in flight is sure of a buffer slot
  assign committed = (OF_CNT_W + 1)'(of_cnt_r) + (OF_CNT_W + 1)'(v2_r && s2_r.emit)
                   + (OF_CNT_W + 1)'(v3_r) + (OF_CNT_W + 1)'(v4_r);
  assign q_pop     = !q_empty && (committed < (OF_CNT_W + 1)'(OF_DEPTH));

  bfrs_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line_store (
    .clk     (clk),
    .wr_en   (v2_r),
    .wr_addr (s2_r.ls_addr),
    .wr_data (s2_r.pixel),
    .rd_addr (q_head.ls_addr),
    .rd_data (ls_rdata)
  );

  bfrs_ram #(.WIDTH(COLSUM_W), .DEPTH(MAX_WIDTH)) u_column_sums (
    .clk     (clk),
    .wr_en   (v2_r),
    .wr_addr (s2_r.col),
    .wr_data (col_new),
    .rd_addr (q_head.col),
    .rd_data (cs_rdata)
  );

  // Vertical and horizontal running sums; forward a write from the cycle before
  always_comb begin
    old_px  = !s2_r.r_ge_k ? '0 : (fwd_ls_r ? last_px_r : ls_rdata);
    cs_in   = s2_r.r_zero ? '0 : (fwd_cs_r ? last_col_r : cs_rdata);
    col_new = cs_in + COLSUM_W'(s2_r.pixel) - COLSUM_W'(old_px);
    ws_base = s2_r.c_zero ? '0 : ws_r;
    ws_sub  = s2_r.c_ge_k ? recent_r[s2_r.hslot] : '0;
    ws_nxt  = v2_r ? (ws_base + WSUM_W'(col_new) - WSUM_W'(ws_sub)) : ws_r;
  end

  // Control registers of the pipeline and the running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ws_r <= '0;
      for (int i = 0; i < MAX_KERNEL; i++) begin
        recent_r[i] <= '0;
      end
    end else begin
      v2_r <= q_pop;
      v3_r <= v2_r && s2_r.emit;
      v4_r <= v3_r;
      ws_r <= ws_nxt;
      if (v2_r) begin
        recent_r[s2_r.hslot] <= col_new;
      end
    end
  end

  // Payload of the pipeline
  always_ff @(posedge clk) begin
    s2_r         <= q_head;
    fwd_ls_r     <= v2_r && (s2_r.ls_addr == q_head.ls_addr);
    fwd_cs_r     <= v2_r && (s2_r.col == q_head.col);
    last_px_r    <= s2_r.pixel;
    last_col_r   <= col_new;
    recip_r      <= bfrs_recip(k_eff);
    row_end3_r   <= s2_r.row_end;
    frame_end3_r <= s2_r.frame_end;
    prod_r       <= PROD_W'(ws_r) * PROD_W'(recip_r);
    row_end4_r   <= row_end3_r;
    frame_end4_r <= frame_end3_r;
  end

  // Truncated quotient, saturated to a pixel
  always_comb begin
    quot           = prod_r[PROD_W-1:RECIP_SH];
    res.mean_value = (quot > QUOT_W'(MEAN_MAX)) ? PIX_W'(MEAN_MAX) : quot[PIX_W-1:0];
    res.row_end    = row_end4_r;
    res.frame_end  = frame_end4_r;
  end

  // Result buffer toward the output channel
  assign of_pop             = out_res.valid && out_res.ready;
  assign out_res.valid      = (of_cnt_r != '0);
  assign out_res.mean_value = of_mem_r[of_rd_r].mean_value;
  assign out_res.row_end    = of_mem_r[of_rd_r].row_end;
  assign out_res.frame_end  = of_mem_r[of_rd_r].frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      if (v4_r) begin
        of_wr_r <= (of_wr_r == OF_AW'(OF_DEPTH - 1)) ? '0 : of_wr_r + OF_AW'(1);
      end
      if (of_pop) begin
        of_rd_r <= (of_rd_r == OF_AW'(OF_DEPTH - 1)) ? '0 : of_rd_r + OF_AW'(1);
      end
      of_cnt_r <= of_cnt_r + OF_CNT_W'(v4_r) - OF_CNT_W'(of_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r) begin
      of_mem_r[of_wr_r] <= res;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/box_filter_running_sum_unit.sv
// ----------------------------------------------------------------------------
// box_filter_running_sum_unit
// Streaming k by k box mean over an 8-bit grey image.
// ----------------------------------------------------------------------------
// Pixels enter on in_pix in raster order, one word per pixel. Each pixel whose
// window is complete (at least k rows and k columns seen) yields one word on
// out_res: the window sum divided by k*k, truncated, with row_end on the last
// mean of an output row and frame_end on the last mean of the frame.
// Throughput is one pixel per clock while out_res does not stall; the back end
// reads its line store and column-sum memories once per pixel and writes them back the next cycle.
// Each accepted pixel passes the queue, memory read, running sums and reciprocal
// multiply before its result word becomes valid.
// The cfg_ port sets image width, height and kernel size; any register write
// restarts the frame at row zero, column zero. Write only while idle.
// Reset loads 640 x 480 with k = 3 and empties the queue and result buffer.
// The memories are not cleared; every entry is written before it is used.
// When out_res stalls, the result buffer fills, the back end stops draining
// the four-word queue, and in_pix.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_running_sum_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfrs_pkg::CFG_DATA_W-1:0] cfg_data,
  bfrs_in_if.sink                         in_pix,
  bfrs_out_if.source                      out_res
);
  import bfrs_pkg::*;

  logic [CFG_W_W-1:0] width_r;
  logic [CFG_H_W-1:0] height_r;
  logic [CFG_K_W-1:0] kernel_r;
  logic               restart;

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [K_W-1:0]   k_eff;

  logic        q_push, q_pop, q_full, q_empty;
  bfrs_entry_t q_in, q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W_W'(RST_WIDTH);
      height_r <= CFG_H_W'(RST_HEIGHT);
      kernel_r <= CFG_K_W'(RST_KERNEL);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_W_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[CFG_H_W-1:0];
        CFG_KERNEL_SIZE:  kernel_r <= cfg_data[CFG_K_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_index == CFG_IMAGE_WIDTH ||
                              cfg_index == CFG_IMAGE_HEIGHT ||
                              cfg_index == CFG_KERNEL_SIZE);

  // Clamp sizes: zero counts as one, oversize saturates
  always_comb begin
    if (width_r == '0)                 w_eff = WID_W'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = WID_W'(MAX_WIDTH);
    else                               w_eff = WID_W'(width_r);
    if (height_r == '0)                   h_eff = HGT_W'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = HGT_W'(MAX_HEIGHT);
    else                                  h_eff = HGT_W'(height_r);
    if (kernel_r == '0)                   k_eff = K_W'(1);
    else if (int'(kernel_r) > MAX_KERNEL) k_eff = K_W'(MAX_KERNEL);
    else                                  k_eff = K_W'(kernel_r);
  end

  bfrs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .k_eff   (k_eff),
    .in_pix  (in_pix),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  bfrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  bfrs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .k_eff   (k_eff),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

  // Queue is never written when full nor read when empty
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

  // Frame end only ever marks the end of a row
  a_frame_on_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.frame_end |-> out_res.row_end)
    else $error("frame end without row end");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid) else $error("result valid right after reset");

endmodule

`default_nettype wire
